@@ src/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Shared payload types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int DEF_CAPACITY  = 256;
	localparam int DEF_KEY_WIDTH = 32;
	localparam int VALUE_W       = 32;
	localparam int COUNT_W       = 9;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                        command;
		logic signed [VALUE_W-1:0]  new_value;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  top_value;
		status_t                    status;
		logic [COUNT_W-1:0]         element_count;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_KEY,
		S_DN_CHK,
		S_DN_RL,
		S_DN_CMP,
		S_FIN
	} ctl_state_t;

	typedef enum logic [2:0] {
		RD_PARENT,
		RD_ROOT,
		RD_LAST,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_item;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_top;
		logic    cap_key;
		logic    cap_left;
		logic    up_step;
		logic    dn_step;
		logic    wr_key;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    set_status;
		status_t status_code;
		logic    load_out;
	} hpq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_extract;
		logic full;
		logic empty;
		logic at_root;
		logic up_greater;
		logic has_left;
		logic has_right;
		logic best_is_pos;
	} hpq_stat_t;

endpackage

@@ src/max_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Array-based binary max-heap with insert and extract-max requests, one
// result per request.
// ----------------------------------------------------------------------------
//   channel   signals                          payload
//   item      item_valid / item_stall / item   command, new_value
//   result    result_valid / result_stall      top_value, status,
//             / result                         element_count
//
// One request at a time, accepted again once the last one has loaded its result.
// Insert sifts the key up and extract sifts it down; the key moves at most 8 levels
// on insert and 7 on extract. Refused requests move no key and only set the status.
// Reset clears the fill count; memory contents are never read before written.
// A stalled result holds; the next request is accepted and waits in its last state.
module max_heap_priority_queue #(
	parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mhpq_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mhpq_pkg::result_t result
);
	import mhpq_pkg::*;

	hpq_cmd_t  cmd;
	hpq_stat_t stat;

	mhpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	mhpq_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

@@ src/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Max-heap priority queue controller
// Sequences insert sift-up and extract sift-down steps and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  mhpq_pkg::hpq_stat_t stat,
	output mhpq_pkg::hpq_cmd_t  cmd
);
	import mhpq_pkg::*;

	ctl_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.rd_sel      = RD_ROOT;
		cmd.status_code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.is_extract) begin
					if (stat.full) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_FULL;
						state_d         = S_FIN;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = S_UP_CHK;
					end
				end else begin
					if (stat.empty) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_EMPTY;
						state_d         = S_FIN;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_sel  = RD_ROOT;
						cmd.cnt_dec = 1'b1;
						state_d     = S_DN_LAST;
					end
				end
			end
			S_UP_CHK: begin
				if (stat.at_root) begin
					cmd.wr_key = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_greater) begin
					cmd.up_step = 1'b1;
					state_d     = S_UP_CHK;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_DN_LAST: begin
				cmd.cap_top = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_LAST;
				state_d     = S_DN_KEY;
			end
			S_DN_KEY: begin
				cmd.cap_key = 1'b1;
				state_d     = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (!stat.has_left) begin
					cmd.wr_key = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEFT;
					state_d    = S_DN_RL;
				end
			end
			S_DN_RL: begin
				cmd.cap_left = 1'b1;
				if (stat.has_right) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RIGHT;
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (stat.best_is_pos) begin
					cmd.wr_key = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.dn_step = 1'b1;
					state_d     = S_DN_CHK;
				end
			end
			S_FIN: begin
				// Hold the finished request until the result register is free.
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ src/mhpq_datapath.sv @@
// ----------------------------------------------------------------------------
// Max-heap priority queue datapath
// Heap memory, hole position, carried key, fill count and result register.
// ----------------------------------------------------------------------------
module mhpq_datapath #(
	parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mhpq_pkg::item_t     item,
	input  mhpq_pkg::hpq_cmd_t  cmd,
	output mhpq_pkg::hpq_stat_t stat,
	output mhpq_pkg::result_t   result
);
	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;

	logic signed [KEY_WIDTH-1:0] heap_q [CAPACITY];
	logic signed [KEY_WIDTH-1:0] rd_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic signed [KEY_WIDTH-1:0] left_q;
	logic signed [KEY_WIDTH-1:0] top_q;
	logic [CW-1:0]               count_q;
	logic [AW-1:0]               pos_q;
	op_t                         op_q;
	status_t                     status_q;
	result_t                     result_q;

	logic [63:0]                 in_ext;
	logic signed [KEY_WIDTH-1:0] in_key;
	logic signed [63:0]          top_ext;
	logic [CW+8:0]               count_ext;
	logic [AW-1:0]               parent;
	logic [IW-1:0]               left_idx;
	logic [IW-1:0]               right_idx;
	logic [IW-1:0]               count_w;
	logic [AW-1:0]               rd_addr;
	logic                        has_right;
	logic                        left_gt;
	logic                        right_gt;
	logic signed [KEY_WIDTH-1:0] cand;
	logic signed [KEY_WIDTH-1:0] best_val;
	logic [AW-1:0]               best_idx;
	logic [AW-1:0]               wr_addr;
	logic signed [KEY_WIDTH-1:0] wr_data;
	logic                        wr_en;

	// The input word is taken unsigned, then cut or widened to the key width.
	assign in_ext  = {32'd0, item.new_value};
	assign in_key  = in_ext[KEY_WIDTH-1:0];

	assign parent    = AW'((pos_q - AW'(1)) >> 1);
	assign left_idx  = IW'({pos_q, 1'b1});
	assign right_idx = left_idx + IW'(1);
	assign count_w   = IW'(count_q);
	assign has_right = right_idx < count_w;

	assign left_gt  = left_q > key_q;
	assign cand     = left_gt ? left_q : key_q;
	assign right_gt = has_right && (rd_q > cand);
	assign best_val = right_gt ? rd_q : left_q;
	assign best_idx = right_gt ? right_idx[AW-1:0] : left_idx[AW-1:0];

	always_comb begin
		stat.is_extract  = (op_q == OP_EXTRACT);
		stat.full        = (count_q == CW'(CAPACITY));
		stat.empty       = (count_q == '0);
		stat.at_root     = (pos_q == '0);
		stat.up_greater  = key_q > rd_q;
		stat.has_left    = left_idx < count_w;
		stat.has_right   = has_right;
		stat.best_is_pos = !left_gt && !right_gt;
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_PARENT: rd_addr = parent;
			RD_ROOT:   rd_addr = '0;
			RD_LAST:   rd_addr = count_q[AW-1:0];
			RD_LEFT:   rd_addr = left_idx[AW-1:0];
			RD_RIGHT:  rd_addr = right_idx[AW-1:0];
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_en   = cmd.up_step || cmd.dn_step || cmd.wr_key;
		wr_addr = pos_q;
		priority if (cmd.up_step)
			wr_data = rd_q;
		else if (cmd.dn_step)
			wr_data = best_val;
		else
			wr_data = key_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			heap_q[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= heap_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= item.command;
			key_q    <= in_key;
			pos_q    <= (item.command == OP_INSERT) ? count_q[AW-1:0] : '0;
			status_q <= ST_OK;
			top_q    <= '0;
		end else begin
			if (cmd.set_status)
				status_q <= cmd.status_code;
			if (cmd.cap_top)
				top_q <= rd_q;
			if (cmd.cap_key)
				key_q <= rd_q;
			if (cmd.cap_left)
				left_q <= rd_q;
			if (cmd.up_step)
				pos_q <= parent;
			else if (cmd.dn_step)
				pos_q <= best_idx;
		end
	end

	assign top_ext   = 64'(top_q);
	assign count_ext = (CW + 9)'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.top_value     <= top_ext[VALUE_W-1:0];
			result_q.status        <= status_q;
			result_q.element_count <= count_ext[COUNT_W-1:0];
		end
	end

	assign result = result_q;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Max-heap priority queue testbench
// Drives insert and extract-max requests through the valid/stall channels,
// with random idle and stall bursts on both sides. A behavioral heap in the
// bench predicts every result, and each result is checked field by field in
// order. A short table of directed requests comes first. Random phases then
// fill the heap past capacity, drain it past empty and mix the two.
// ----------------------------------------------------------------------------
module testbench;

	import mhpq_pkg::*;

	localparam int CAPACITY   = DEF_CAPACITY;
	localparam int ITEM_GOAL  = 1150;
	localparam int QUIET_TAIL = 150;
	localparam int DRAIN_WAIT = 100;

	typedef struct {
		item_t   req;
		bit      typed;
		result_t want;
	} directed_row_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Bench copy of the heap.
	logic signed [VALUE_W-1:0] heap_keys [CAPACITY];
	int                        heap_fill = 0;
	int                        peak_fill = 0;

	result_t       pending_results [$];
	directed_row_t directed_rows [$];
	result_t       oldest_want;

	int  requests_sent   = 0;
	int  results_checked = 0;
	int  mismatch_count  = 0;
	int  full_refusals   = 0;
	int  empty_refusals  = 0;
	int  stall_left      = 0;
	bit  quiet_tail      = 1'b0;

	max_heap_priority_queue uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Applies one request to the bench heap and returns the result it causes.
	function automatic result_t heap_apply(item_t req);
		result_t                   r;
		int                        pos;
		int                        parent;
		int                        best;
		int                        child;
		bit                        done;
		logic signed [VALUE_W-1:0] tmp;
		r = '0;
		r.status = ST_OK;
		if (req.command == OP_INSERT) begin
			if (heap_fill >= CAPACITY) begin
				r.status = ST_FULL;
				full_refusals++;
			end else begin
				pos = heap_fill;
				heap_keys[pos] = req.new_value;
				heap_fill++;
				done = 1'b0;
				while (pos > 0 && !done) begin
					parent = (pos - 1) / 2;
					if (heap_keys[pos] > heap_keys[parent]) begin
						tmp = heap_keys[pos];
						heap_keys[pos] = heap_keys[parent];
						heap_keys[parent] = tmp;
						pos = parent;
					end else begin
						done = 1'b1;
					end
				end
			end
		end else begin
			if (heap_fill == 0) begin
				r.status = ST_EMPTY;
				empty_refusals++;
			end else begin
				r.top_value = heap_keys[0];
				heap_fill--;
				heap_keys[0] = heap_keys[heap_fill];
				pos = 0;
				done = 1'b0;
				while (!done) begin
					best = pos;
					child = 2 * pos + 1;
					if (child < heap_fill && heap_keys[child] > heap_keys[best])
						best = child;
					child = 2 * pos + 2;
					if (child < heap_fill && heap_keys[child] > heap_keys[best])
						best = child;
					if (best == pos) begin
						done = 1'b1;
					end else begin
						tmp = heap_keys[pos];
						heap_keys[pos] = heap_keys[best];
						heap_keys[best] = tmp;
						pos = best;
					end
				end
			end
		end
		if (heap_fill > peak_fill)
			peak_fill = heap_fill;
		r.element_count = heap_fill[COUNT_W-1:0];
		return r;
	endfunction

	// Keys lean toward small values so that ties and sign changes are common.
	function automatic logic [VALUE_W-1:0] draw_key();
		logic [VALUE_W-1:0] k;
		case ($urandom_range(0, 5))
			0: k = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1, 2: k = $urandom_range(0, 8) - 4;
			default: k = $urandom;
		endcase
		return k;
	endfunction

	task automatic add_row(op_t cmd, logic [VALUE_W-1:0] key, bit typed,
			logic [VALUE_W-1:0] top, status_t st, int cnt);
		directed_row_t row;
		row.req.command = cmd;
		row.req.new_value = key;
		row.typed = typed;
		row.want.top_value = top;
		row.want.status = st;
		row.want.element_count = cnt[COUNT_W-1:0];
		directed_rows.push_back(row);
	endtask

	task automatic send_request(item_t req, bit typed, result_t typed_want);
		result_t want;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		want = heap_apply(req);
		if (typed)
			want = typed_want;
		pending_results.push_back(want);
		requests_sent++;
	endtask

	task automatic run_mixed(int n, int insert_pct);
		item_t req;
		repeat (n) begin
			req.command = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
			req.new_value = draw_key();
			send_request(req, 1'b0, '0);
		end
	endtask

	// Result side: check accepted results, then plan the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: top %0d status %0d count %0d",
						result.top_value, result.status, result.element_count);
			end else begin
				oldest_want = pending_results.pop_front();
				results_checked++;
				if (result.top_value !== oldest_want.top_value
						|| result.status !== oldest_want.status
						|| result.element_count !== oldest_want.element_count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch on result %0d: expected top %0d status %0d count %0d, got top %0d status %0d count %0d",
							results_checked, oldest_want.top_value, oldest_want.status,
							oldest_want.element_count, result.top_value, result.status,
							result.element_count);
				end
			end
		end
		if (stall_left > 0)
			stall_left--;
		else if (!quiet_tail && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 8);
		result_stall <= (stall_left > 0);
	end

	initial begin
		item_t req;
		// Empty extract, extremes, ties, then drain back past empty.
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 0);
		add_row(OP_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0, ST_OK, 1);
		add_row(OP_INSERT, 32'h8000_0000, 1'b1, 32'h0, ST_OK, 2);
		add_row(OP_INSERT, 32'h0000_0000, 1'b1, 32'h0, ST_OK, 3);
		add_row(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK, 4);
		add_row(OP_INSERT, 32'h0000_0005, 1'b1, 32'h0, ST_OK, 5);
		add_row(OP_INSERT, 32'h0000_0005, 1'b1, 32'h0, ST_OK, 6);
		add_row(OP_INSERT, 32'h0000_0005, 1'b1, 32'h0, ST_OK, 7);
		add_row(OP_EXTRACT, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK, 6);
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b1, 32'h0000_0005, ST_OK, 5);
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b1, 32'h0000_0005, ST_OK, 4);
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b1, 32'h0000_0005, ST_OK, 3);
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK, 2);
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK, 1);
		add_row(OP_EXTRACT, 32'hAAAA_AAAA, 1'b1, 32'h8000_0000, ST_OK, 0);
		add_row(OP_EXTRACT, 32'h5555_5555, 1'b1, 32'h0, ST_EMPTY, 0);
		add_row(OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0, ST_OK, 0);
		add_row(OP_INSERT, 32'h5555_5555, 1'b0, '0, ST_OK, 0);
		add_row(OP_INSERT, 32'h1234_5678, 1'b0, '0, ST_OK, 0);
		add_row(OP_INSERT, 32'hFFFF_FF9C, 1'b0, '0, ST_OK, 0);
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b0, '0, ST_OK, 0);
		add_row(OP_EXTRACT, 32'h0000_0000, 1'b0, '0, ST_OK, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		run_mixed(300, 60);

		// Fill to capacity, then a few refused inserts.
		while (heap_fill < CAPACITY) begin
			req.command = OP_INSERT;
			req.new_value = draw_key();
			send_request(req, 1'b0, '0);
		end
		repeat (4) begin
			req.command = OP_INSERT;
			req.new_value = draw_key();
			send_request(req, 1'b0, '0);
		end
		run_mixed(60, 50);

		// Drain past empty.
		while (heap_fill > 0) begin
			req.command = OP_EXTRACT;
			req.new_value = $urandom;
			send_request(req, 1'b0, '0);
		end
		repeat (3) begin
			req.command = OP_EXTRACT;
			req.new_value = $urandom;
			send_request(req, 1'b0, '0);
		end

		if (ITEM_GOAL - requests_sent > QUIET_TAIL)
			run_mixed(ITEM_GOAL - requests_sent - QUIET_TAIL, 55);
		quiet_tail = 1'b1;
		run_mixed(QUIET_TAIL, 55);
		item_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("summary: %0d requests sent, %0d results checked, %0d mismatches",
			requests_sent, results_checked, mismatch_count);
		$display("summary: peak fill %0d of %0d, %0d full refusals, %0d empty refusals",
			peak_fill, CAPACITY, full_refusals, empty_refusals);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ max_heap_priority_queue.f @@
src/mhpq_pkg.sv
src/mhpq_ctrl.sv
src/mhpq_datapath.sv
src/max_heap_priority_queue.sv
dv/testbench.sv
